[rtl/aalp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aalp_pkg
// Shared types, character codes and helper functions of the angle line parser.
// ----------------------------------------------------------------------------
package aalp_pkg;

	localparam int LINE_CAPACITY_DEF = 48;
	localparam int FRAC_DIGITS       = 6;
	localparam int QUEUE_DEPTH       = 4;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_N     = 8'h4E;
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_EQUAL = 8'h3D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VTAB  = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;

	typedef enum logic [10:0] {
		PH_LEAD     = 11'b000_0000_0001,
		PH_PFX_A    = 11'b000_0000_0010,
		PH_PFX_N    = 11'b000_0000_0100,
		PH_PFX_SEP  = 11'b000_0000_1000,
		PH_WS2      = 11'b000_0001_0000,
		PH_SIGNED   = 11'b000_0010_0000,
		PH_INT      = 11'b000_0100_0000,
		PH_DOTFIRST = 11'b000_1000_0000,
		PH_FRAC     = 11'b001_0000_0000,
		PH_DONE     = 11'b010_0000_0000,
		PH_FAIL     = 11'b100_0000_0000
	} aalp_phase_t;

	// one finished line, handed from the front to the back
	typedef struct packed {
		logic        neg;
		logic        ok;
		logic [15:0] int_part;
		logic [19:0] frac;
		logic [2:0]  frac_cnt;
	} aalp_line_t;

	// frac * 2^16 / 10^cnt ~= (frac * mult) >> shift, low by at most one
	typedef struct packed {
		logic [16:0] mult;
		logic [4:0]  shift;
		logic [19:0] divisor;
	} aalp_recip_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VTAB) || (c == CH_FF);
	endfunction

	function automatic logic is_dig(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic aalp_recip_t recip_of(input logic [2:0] cnt);
		aalp_recip_t r;
		unique case (cnt)
			3'd0: r = '{mult: 17'd65536,  shift: 5'd0,  divisor: 20'd1};
			3'd1: r = '{mult: 17'd104857, shift: 5'd4,  divisor: 20'd10};
			3'd2: r = '{mult: 17'd83886,  shift: 5'd7,  divisor: 20'd100};
			3'd3: r = '{mult: 17'd67108,  shift: 5'd10, divisor: 20'd1000};
			3'd4: r = '{mult: 17'd107374, shift: 5'd14, divisor: 20'd10000};
			3'd5: r = '{mult: 17'd85899,  shift: 5'd17, divisor: 20'd100000};
			default: r = '{mult: 17'd68719, shift: 5'd20, divisor: 20'd1000000};
		endcase
		return r;
	endfunction

endpackage

[rtl/aalp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aalp_byte_if / aalp_res_if
// Valid/ready channels for received bytes and for parsed angle results.
// ----------------------------------------------------------------------------
interface aalp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface aalp_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] angle_q16;
	logic               parse_ok;

	modport source (output valid, output angle_q16, output parse_ok, input ready);
	modport sink   (input valid, input angle_q16, input parse_ok, output ready);
endinterface

[rtl/ascii_angle_line_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_angle_line_parser
// Streams ASCII bytes and turns each text line into a signed Q16.16 angle.
// ----------------------------------------------------------------------------
// usage
// rx carries one received byte per transfer; one byte can be taken every
// cycle. result carries angle_q16 and parse_ok, one transfer per line feed;
// no other byte gives a result. carriage return is ignored.
// path: the result of a line feed passes the line queue, then four back-end
// stages (reciprocal multiply, shift, check multiply, correct and sum),
// then the output register.
// throughput: one byte per cycle, and one result per cycle for back to back
// line feeds; the front scanner and the back end are parted by a 4-line
// queue, and rx ready drops only while that queue is full.
// when result is stalled the back end holds, the queue fills, then rx stalls.
// reset clears the line in progress, the queue, the pipeline and the
// last good angle (zero); no results are pending after reset.
// a failed line reports the last good angle with parse_ok low.
// ----------------------------------------------------------------------------
module ascii_angle_line_parser #(
	parameter int LINE_CAPACITY = aalp_pkg::LINE_CAPACITY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	aalp_byte_if.sink  rx,
	aalp_res_if.source result
);
	import aalp_pkg::*;

	aalp_line_t push_line, head_line;
	logic       push, pop, empty, full;

	aalp_front #(.LINE_CAPACITY(LINE_CAPACITY)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.queue_full (full),
		.line_push  (push),
		.line_rec   (push_line)
	);

	aalp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_line (push_line),
		.pop       (pop),
		.head_line (head_line),
		.empty     (empty),
		.full      (full)
	);

	aalp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_line  (head_line),
		.head_valid (!empty),
		.pop        (pop),
		.result     (result)
	);

endmodule

[rtl/aalp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aalp_front
// Byte-wide line scanner: prefix, sign, integer and fraction accumulation.
// ----------------------------------------------------------------------------
module aalp_front #(
	parameter int LINE_CAPACITY = aalp_pkg::LINE_CAPACITY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	aalp_byte_if.sink           rx,
	input  logic                queue_full,
	output logic                line_push,
	output aalp_pkg::aalp_line_t line_rec
);
	import aalp_pkg::*;

	localparam int LW = $clog2(LINE_CAPACITY);

	aalp_phase_t  ph_q, ph_n;
	logic [LW-1:0] len_q;
	logic          neg_q, neg_n;
	logic          saw_q, saw_n;
	logic [15:0]   int_q, int_n;
	logic [19:0]   frac_q, frac_n;
	logic [2:0]    cnt_q, cnt_n;

	logic [7:0]  c;
	logic [3:0]  dval;
	logic [19:0] int_mac;
	logic [15:0] int_dig;
	logic [19:0] frac_dig;
	logic [2:0]  cnt_dig;
	logic        start;
	logic        xfer;

	assign c        = rx.rx_byte;
	assign dval     = c[3:0];
	assign xfer     = rx.valid && rx.ready;
	assign rx.ready = !queue_full;

	assign int_mac = {4'b0, int_q} * 20'd10 + {16'b0, dval};
	assign int_dig = (int_mac > 20'd65535) ? 16'hFFFF : int_mac[15:0];

	// digits past the fraction limit are dropped but still count as seen
	always_comb begin
		if (cnt_q < 3'(FRAC_DIGITS)) begin
			frac_dig = 20'(frac_q * 20'd10 + {16'b0, dval});
			cnt_dig  = cnt_q + 3'd1;
		end else begin
			frac_dig = frac_q;
			cnt_dig  = cnt_q;
		end
	end

	always_comb begin
		ph_n   = ph_q;
		neg_n  = neg_q;
		saw_n  = saw_q;
		int_n  = int_q;
		frac_n = frac_q;
		cnt_n  = cnt_q;
		start  = 1'b0;
		unique case (ph_q)
			PH_LEAD: begin
				if (!is_ws(c)) begin
					if (c == CH_A) ph_n = PH_PFX_A;
					else start = 1'b1;
				end
			end
			PH_PFX_A:   ph_n = (c == CH_N) ? PH_PFX_N : PH_FAIL;
			PH_PFX_N:   ph_n = (c == CH_G) ? PH_PFX_SEP : PH_FAIL;
			PH_PFX_SEP: begin
				if (c == CH_COMMA || c == CH_COLON || c == CH_EQUAL || is_ws(c)) ph_n = PH_WS2;
				else start = 1'b1;
			end
			PH_WS2: begin
				if (!is_ws(c)) start = 1'b1;
			end
			PH_SIGNED: begin
				if (is_dig(c)) begin
					int_n = int_dig;
					saw_n = 1'b1;
					ph_n  = PH_INT;
				end else if (c == CH_DOT) begin
					ph_n = PH_DOTFIRST;
				end else begin
					ph_n = PH_FAIL;
				end
			end
			PH_INT: begin
				if (is_dig(c)) begin
					int_n = int_dig;
					saw_n = 1'b1;
				end else if (c == CH_DOT) begin
					ph_n = PH_FRAC;
				end else begin
					ph_n = PH_DONE;
				end
			end
			PH_DOTFIRST: begin
				if (is_dig(c)) begin
					frac_n = frac_dig;
					cnt_n  = cnt_dig;
					saw_n  = 1'b1;
					ph_n   = PH_FRAC;
				end else begin
					ph_n = PH_FAIL;
				end
			end
			PH_FRAC: begin
				if (is_dig(c)) begin
					frac_n = frac_dig;
					cnt_n  = cnt_dig;
					saw_n  = 1'b1;
				end else begin
					ph_n = PH_DONE;
				end
			end
			PH_DONE, PH_FAIL: ;
			default: ;
		endcase

		if (start) begin
			priority if (c == CH_PLUS) begin
				ph_n = PH_SIGNED;
			end else if (c == CH_MINUS) begin
				neg_n = 1'b1;
				ph_n  = PH_SIGNED;
			end else if (is_dig(c)) begin
				int_n = int_dig;
				saw_n = 1'b1;
				ph_n  = PH_INT;
			end else if (c == CH_DOT) begin
				ph_n = PH_DOTFIRST;
			end else begin
				ph_n = PH_FAIL;
			end
		end
	end

	assign line_push = xfer && (c == CH_LF);
	assign line_rec  = '{neg: neg_q, ok: saw_q, int_part: int_q, frac: frac_q, frac_cnt: cnt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_LEAD;
			len_q  <= '0;
			neg_q  <= 1'b0;
			saw_q  <= 1'b0;
			int_q  <= '0;
			frac_q <= '0;
			cnt_q  <= '0;
		end else if (xfer && c != CH_CR) begin
			// line feed ends the line; a full buffer drops it
			if (c == CH_LF || len_q >= LW'(LINE_CAPACITY - 1)) begin
				ph_q   <= PH_LEAD;
				len_q  <= '0;
				neg_q  <= 1'b0;
				saw_q  <= 1'b0;
				int_q  <= '0;
				frac_q <= '0;
				cnt_q  <= '0;
			end else begin
				ph_q   <= ph_n;
				len_q  <= len_q + LW'(1);
				neg_q  <= neg_n;
				saw_q  <= saw_n;
				int_q  <= int_n;
				frac_q <= frac_n;
				cnt_q  <= cnt_n;
			end
		end
	end

endmodule

[rtl/aalp_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aalp_queue
// Small first-in first-out buffer of finished lines between front and back.
// ----------------------------------------------------------------------------
module aalp_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  aalp_pkg::aalp_line_t push_line,
	input  logic                 pop,
	output aalp_pkg::aalp_line_t head_line,
	output logic                 empty,
	output logic                 full
);
	import aalp_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	aalp_line_t  mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;

	assign empty     = (cnt_q == '0);
	assign full      = (cnt_q == (PW+1)'(QUEUE_DEPTH));
	assign head_line = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_line;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
			if (pop)  rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + (PW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (PW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[rtl/aalp_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aalp_back
// Converts a finished line to Q16.16: fraction scaling, saturation, sign.
// ----------------------------------------------------------------------------
module aalp_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  aalp_pkg::aalp_line_t head_line,
	input  logic                 head_valid,
	output logic                 pop,
	aalp_res_if.source           result
);
	import aalp_pkg::*;

	logic adv;

	aalp_recip_t rc;
	logic        v_s1, v_s2, v_s3, v_s4;
	aalp_line_t  line_s1, line_s2, line_s3;
	logic [36:0] prod_s1;
	logic [4:0]  shift_s1;
	logic [19:0] div_s1, div_s2, div_s3;
	logic [15:0] quot_s2, quot_s3;
	logic [35:0] qd_s3;
	logic [31:0] mag_s4;
	logic        neg_s4, ok_s4;

	logic [35:0] rem;
	logic [15:0] fq;
	logic [31:0] sat;

	logic               res_valid_q;
	logic signed [31:0] angle_q;
	logic               ok_q;
	logic [31:0]        last_good_q;

	assign adv = !res_valid_q || result.ready;
	assign pop = adv && head_valid;
	assign rc  = recip_of(head_line.frac_cnt);

	// remainder check lifts the estimate when it came out one low
	assign rem = {line_s3.frac, 16'b0} - qd_s3;
	assign fq  = (rem >= {16'b0, div_s3}) ? quot_s3 + 16'd1 : quot_s3;

	always_comb begin
		if (neg_s4) begin
			sat = (mag_s4 > 32'h8000_0000) ? 32'h8000_0000 : mag_s4;
			sat = 32'd0 - sat;
		end else begin
			sat = (mag_s4 > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			res_valid_q <= 1'b0;
			last_good_q <= '0;
		end else if (adv) begin
			v_s1        <= head_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			res_valid_q <= v_s4;
			if (v_s4 && ok_s4) last_good_q <= sat;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			line_s1  <= head_line;
			prod_s1  <= {17'b0, head_line.frac} * {20'b0, rc.mult};
			shift_s1 <= rc.shift;
			div_s1   <= rc.divisor;

			line_s2  <= line_s1;
			quot_s2  <= 16'(prod_s1 >> shift_s1);
			div_s2   <= div_s1;

			line_s3  <= line_s2;
			quot_s3  <= quot_s2;
			qd_s3    <= {20'b0, quot_s2} * {16'b0, div_s2};
			div_s3   <= div_s2;

			mag_s4   <= {line_s3.int_part, 16'b0} + {16'b0, fq};
			neg_s4   <= line_s3.neg;
			ok_s4    <= line_s3.ok;

			angle_q  <= ok_s4 ? sat : last_good_q;
			ok_q     <= ok_s4;
		end
	end

	assign result.valid     = res_valid_q;
	assign result.angle_q16 = angle_q;
	assign result.parse_ok  = ok_q;

endmodule
